@@ hdl/smc1d_pkg.sv @@
// ----------------------------------------------------------------------------
// smc1d_pkg
// Shared types, codes and default sizes of the strided 1-D convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package smc1d_pkg;

  // Default sizes for the top-level parameters.
  localparam int DEF_MAX_FILTERS  = 8;
  localparam int DEF_MAX_CHANNELS = 4;
  localparam int DEF_MAX_TAPS     = 8;
  localparam int DEF_SAMPLE_BITS  = 16;

  localparam int SUM_W = 40;

  // Input commands.
  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_WEIGHT  = 2'd1,
    CMD_BIAS    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_STRIDE   = 2'd0,
    REG_TAPS     = 2'd1,
    REG_CHANNELS = 2'd2,
    REG_FILTERS  = 2'd3
  } reg_idx_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  filter_index;
    logic [1:0]  channel_index;
    logic [2:0]  tap_index;
    logic [15:0] value;
  } in_data_t;

  typedef struct packed {
    logic [2:0]       filter_index_out;
    logic [15:0]      output_position;
    logic [SUM_W-1:0] sum;
    logic             last;
  } out_data_t;

  // Control bits of one window element travelling down the cell row.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tok_ctl_t;

  // Store write strobes for one cell.
  typedef struct packed {
    logic weight_we;
    logic bias_we;
  } wr_ctl_t;

endpackage

`default_nettype wire

@@ hdl/smc1d_cell.sv @@
// ----------------------------------------------------------------------------
// smc1d_cell
// One filter cell: holds its weights and bias, multiplies each passing window
// element by its weight, accumulates, and hands the element to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module smc1d_cell #(
  parameter int SB    = smc1d_pkg::DEF_SAMPLE_BITS,
  parameter int DEPTH = smc1d_pkg::DEF_MAX_CHANNELS * smc1d_pkg::DEF_MAX_TAPS,
  parameter int AW    = 5,
  parameter int ACC_W = 48
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  smc1d_pkg::wr_ctl_t           wr,
  input  wire  [AW-1:0]                wr_addr,
  input  wire  [SB-1:0]                wr_data,
  input  smc1d_pkg::tok_ctl_t          tok_in,
  input  wire  [AW-1:0]                tok_addr_in,
  input  wire  [SB-1:0]                tok_samp_in,
  output smc1d_pkg::tok_ctl_t          tok_out,
  output logic [AW-1:0]                tok_addr_out,
  output logic [SB-1:0]                tok_samp_out,
  output logic                         done,
  output logic [smc1d_pkg::SUM_W-1:0]  sum
);

  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'(40'sh7FFFFFFFFF);
  localparam logic signed [ACC_W-1:0] SMIN = ACC_W'(40'sh8000000000);

  logic [SB-1:0]                wmem [DEPTH];
  logic [SB-1:0]                bias_r;
  logic [SB-1:0]                w_r;
  smc1d_pkg::tok_ctl_t          t1_r, t2_r;
  logic signed [2*SB-1:0]       p_r;
  logic signed [ACC_W-1:0]      acc_r, acc_nxt, base;
  logic [smc1d_pkg::SUM_W-1:0]  sum_r;
  logic                         done_r;

  // Weight store with registered read, and the bias register.
  always_ff @(posedge clk) begin
    if (wr.weight_we) begin
      wmem[wr_addr] <= wr_data;
    end
    if (wr.bias_we) begin
      bias_r <= wr_data;
    end
    w_r          <= wmem[tok_addr_in];
    tok_addr_out <= tok_addr_in;
    tok_samp_out <= tok_samp_in;
    p_r          <= $signed(w_r) * $signed(tok_samp_out);
  end

  // Control of the element pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r   <= '0;
      t2_r   <= '0;
      done_r <= 1'b0;
    end else begin
      t1_r   <= tok_in;
      t2_r   <= t1_r;
      done_r <= t2_r.valid && t2_r.last;
    end
  end

  assign tok_out = t1_r;

  // Accumulate; the bias (scaled to the product format) seeds each sum.
  always_comb begin
    base    = t2_r.first ? (ACC_W'($signed(bias_r)) <<< 12) : acc_r;
    acc_nxt = base + ACC_W'(p_r);
  end

  always_ff @(posedge clk) begin
    if (t2_r.valid) begin
      acc_r <= acc_nxt;
      if (t2_r.last) begin
        if (acc_nxt > SMAX) begin
          sum_r <= SMAX[smc1d_pkg::SUM_W-1:0];
        end else if (acc_nxt < SMIN) begin
          sum_r <= SMIN[smc1d_pkg::SUM_W-1:0];
        end else begin
          sum_r <= acc_nxt[smc1d_pkg::SUM_W-1:0];
        end
      end
    end
  end

  assign done = done_r;
  assign sum  = sum_r;

endmodule

`default_nettype wire

@@ hdl/strided_multichannel_conv1d.sv @@
// ----------------------------------------------------------------------------
// strided_multichannel_conv1d
// Strided multichannel 1-D convolution layer, forward pass before activation.
// ----------------------------------------------------------------------------
// Input items arrive on in_valid/in_ready: samples (channels of a position in
// ascending order), weight writes, bias writes and restart commands. An item
// that does not complete an output window leaves in_ready high for the next.
// When a position completes a stride-aligned window, the sequencer streams
// the channels*taps window elements into a row of filter cells, one per
// cycle; each cell multiplies by its own weight, accumulates and passes the
// element to its neighbor; the results are offered once the last cell has
// taken the final element. The filter_count results leave on out_valid and
// out_ready, one per cycle while out_ready is high, filter 0 first, last set
// on the final one. in_ready stays low from the window start until the final
// result transfer, so a stalled receiver simply holds the block. The
// configuration registers are written over the APB-style port; the user must
// write them only while the block is idle, as the block does not enforce it.
// Synchronous reset clears the counters and sequencer and loads the
// register defaults; weights, biases and samples must be written before use.
// ----------------------------------------------------------------------------
`default_nettype none

module strided_multichannel_conv1d #(
  parameter int MAX_FILTERS  = smc1d_pkg::DEF_MAX_FILTERS,
  parameter int MAX_CHANNELS = smc1d_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_TAPS     = smc1d_pkg::DEF_MAX_TAPS,
  parameter int SAMPLE_BITS  = smc1d_pkg::DEF_SAMPLE_BITS
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  smc1d_pkg::in_data_t  in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output smc1d_pkg::out_data_t out_data,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [3:0]           paddr,
  input  wire  [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int SB    = SAMPLE_BITS;
  localparam int DEPTH = MAX_CHANNELS * MAX_TAPS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int TW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int FW    = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int LOWB  = (SB < 16) ? SB : 16;
  localparam int PW    = 2 * SB;
  localparam int BW    = SB + 12;
  localparam int RAW_W = ((PW > BW) ? PW : BW) + AW + 1;
  localparam int ACC_W = (RAW_W > 41) ? RAW_W : 41;

  // Configuration registers.
  logic [3:0] stride_r, taps_r, filters_r;
  logic [2:0] chans_r;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r  <= 4'd1;
      taps_r    <= 4'd8;
      chans_r   <= 3'd1;
      filters_r <= 4'd1;
    end else if (cfg_we) begin
      unique case (smc1d_pkg::reg_idx_t'(paddr[3:2]))
        smc1d_pkg::REG_STRIDE:   stride_r  <= pwdata[3:0];
        smc1d_pkg::REG_TAPS:     taps_r    <= pwdata[3:0];
        smc1d_pkg::REG_CHANNELS: chans_r   <= pwdata[2:0];
        smc1d_pkg::REG_FILTERS:  filters_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (smc1d_pkg::reg_idx_t'(paddr[3:2]))
      smc1d_pkg::REG_STRIDE:   prdata = {28'd0, stride_r};
      smc1d_pkg::REG_TAPS:     prdata = {28'd0, taps_r};
      smc1d_pkg::REG_CHANNELS: prdata = {29'd0, chans_r};
      smc1d_pkg::REG_FILTERS:  prdata = {28'd0, filters_r};
      default:                 prdata = '0;
    endcase
  end

  // Effective counts: zero acts as one, large values clamp to the maximum.
  logic [3:0] stride_e, taps_e, filts_e;
  logic [2:0] chans_e;

  always_comb begin
    if (stride_r == 4'd0)       stride_e = 4'd1;
    else if (stride_r > 4'd8)   stride_e = 4'd8;
    else                        stride_e = stride_r;
    if (taps_r == 4'd0)                  taps_e = 4'd1;
    else if (32'(taps_r) > MAX_TAPS)     taps_e = 4'(MAX_TAPS);
    else                                 taps_e = taps_r;
    if (chans_r == 3'd0)                 chans_e = 3'd1;
    else if (32'(chans_r) > MAX_CHANNELS) chans_e = 3'(MAX_CHANNELS);
    else                                 chans_e = chans_r;
    if (filters_r == 4'd0)               filts_e = 4'd1;
    else if (32'(filters_r) > MAX_FILTERS) filts_e = 4'(MAX_FILTERS);
    else                                 filts_e = filters_r;
  end

  // Decode of the accepted item.
  smc1d_pkg::cmd_t cmd;
  logic            in_xfer, samp_ok, pos_done, wt_ok;
  logic [SB-1:0]   value_s;

  assign cmd      = smc1d_pkg::cmd_t'(in_data.command);
  assign in_xfer  = in_valid && in_ready;
  assign samp_ok  = in_xfer && (cmd == smc1d_pkg::CMD_SAMPLE) &&
                    ({1'b0, in_data.channel_index} < chans_e);
  assign pos_done = samp_ok && (32'(in_data.channel_index) == 32'(chans_e) - 1);
  assign wt_ok    = (32'(in_data.channel_index) < MAX_CHANNELS) &&
                    (32'(in_data.tap_index) < MAX_TAPS);
  assign value_s  = (SB <= 16) ? SB'($signed(in_data.value[LOWB-1:0]))
                               : SB'(in_data.value[LOWB-1:0]);

  // Window shift lines, one per channel.
  logic [SB-1:0] win_r [MAX_CHANNELS][MAX_TAPS];

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      if (samp_ok && (32'(in_data.channel_index) == k)) begin
        win_r[k][0] <= value_s;
        for (int u = 1; u < MAX_TAPS; u++) begin
          win_r[k][u] <= win_r[k][u-1];
        end
      end
    end
  end

  // Position, stride phase and window counters; emission decision.
  logic [15:0] pos_r, pos_nxt, wc_r, wc_emit_r;
  logic [2:0]  phase_r, phase_nxt;
  logic        emit;

  always_comb begin
    pos_nxt   = (pos_r != 16'hFFFF) ? pos_r + 16'd1 : pos_r;
    phase_nxt = phase_r;
    emit      = 1'b0;
    if (pos_nxt == 16'(taps_e)) begin
      emit      = 1'b1;
      phase_nxt = 3'd0;
    end else if (pos_nxt > 16'(taps_e)) begin
      if (4'(phase_r) + 4'd1 >= stride_e) begin
        emit      = 1'b1;
        phase_nxt = 3'd0;
      end else begin
        phase_nxt = phase_r + 3'd1;
      end
    end
  end

  // Sequencer.
  smc1d_pkg::state_t state_r;
  logic [CW-1:0]     c_r;
  logic [TW-1:0]     u_r;
  logic [FW-1:0]     f_r;
  logic              seq_last;
  logic              row_done;

  assign in_ready = (state_r == smc1d_pkg::ST_IDLE);
  assign seq_last = (32'(c_r) == 32'(chans_e) - 1) && (32'(u_r) == 32'(taps_e) - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smc1d_pkg::ST_IDLE;
      pos_r   <= '0;
      phase_r <= '0;
      wc_r    <= '0;
      c_r     <= '0;
      u_r     <= '0;
      f_r     <= '0;
    end else begin
      unique case (state_r)
        smc1d_pkg::ST_IDLE: begin
          if (in_xfer && (cmd == smc1d_pkg::CMD_RESTART)) begin
            pos_r   <= '0;
            phase_r <= '0;
            wc_r    <= '0;
          end else if (pos_done) begin
            pos_r   <= pos_nxt;
            phase_r <= phase_nxt;
            if (emit) begin
              wc_emit_r <= wc_r;
              wc_r      <= wc_r + 16'd1;
              c_r       <= '0;
              u_r       <= '0;
              state_r   <= smc1d_pkg::ST_RUN;
            end
          end
        end
        smc1d_pkg::ST_RUN: begin
          if (seq_last) begin
            state_r <= smc1d_pkg::ST_WAIT;
          end else if (32'(u_r) == 32'(taps_e) - 1) begin
            u_r <= '0;
            c_r <= c_r + CW'(1);
          end else begin
            u_r <= u_r + TW'(1);
          end
        end
        smc1d_pkg::ST_WAIT: begin
          if (row_done) begin
            f_r     <= '0;
            state_r <= smc1d_pkg::ST_EMIT;
          end
        end
        smc1d_pkg::ST_EMIT: begin
          if (out_ready) begin
            if (32'(f_r) == 32'(filts_e) - 1) begin
              state_r <= smc1d_pkg::ST_IDLE;
            end else begin
              f_r <= f_r + FW'(1);
            end
          end
        end
        default: state_r <= smc1d_pkg::ST_IDLE;
      endcase
    end
  end

  // Window element feeding the head of the cell row.
  smc1d_pkg::tok_ctl_t tok   [MAX_FILTERS+1];
  logic [AW-1:0]       taddr [MAX_FILTERS+1];
  logic [SB-1:0]       tsamp [MAX_FILTERS+1];
  smc1d_pkg::tok_ctl_t tok0_r;
  logic [AW-1:0]       taddr0_r;
  logic [SB-1:0]       tsamp0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok0_r <= '0;
    end else begin
      tok0_r.valid <= (state_r == smc1d_pkg::ST_RUN);
      tok0_r.first <= (c_r == '0) && (u_r == '0);
      tok0_r.last  <= seq_last;
    end
    taddr0_r <= AW'(32'(c_r) * MAX_TAPS + 32'(u_r));
    tsamp0_r <= win_r[c_r][u_r];
  end

  assign tok[0]   = tok0_r;
  assign taddr[0] = taddr0_r;
  assign tsamp[0] = tsamp0_r;

  // Store write address shared by all cells.
  logic [AW-1:0] wr_addr;
  assign wr_addr = AW'(32'(in_data.channel_index) * MAX_TAPS + 32'(in_data.tap_index));

  // Row of filter cells.
  logic                        done_c [MAX_FILTERS];
  logic [smc1d_pkg::SUM_W-1:0] sum_c  [MAX_FILTERS];

  for (genvar k = 0; k < MAX_FILTERS; k++) begin : g_cell
    smc1d_pkg::wr_ctl_t wr;
    assign wr.weight_we = in_xfer && (cmd == smc1d_pkg::CMD_WEIGHT) && wt_ok &&
                          (32'(in_data.filter_index) == k);
    assign wr.bias_we   = in_xfer && (cmd == smc1d_pkg::CMD_BIAS) &&
                          (32'(in_data.filter_index) == k);

    smc1d_cell #(
      .SB    (SB),
      .DEPTH (DEPTH),
      .AW    (AW),
      .ACC_W (ACC_W)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .wr           (wr),
      .wr_addr      (wr_addr),
      .wr_data      (value_s),
      .tok_in       (tok[k]),
      .tok_addr_in  (taddr[k]),
      .tok_samp_in  (tsamp[k]),
      .tok_out      (tok[k+1]),
      .tok_addr_out (taddr[k+1]),
      .tok_samp_out (tsamp[k+1]),
      .done         (done_c[k]),
      .sum          (sum_c[k])
    );
  end

  // The last cell sees the final element after all the others.
  assign row_done = done_c[MAX_FILTERS-1];

  // Result channel.
  assign out_valid                 = (state_r == smc1d_pkg::ST_EMIT);
  assign out_data.filter_index_out = 3'(f_r);
  assign out_data.output_position  = wc_emit_r;
  assign out_data.sum              = sum_c[f_r];
  assign out_data.last             = (32'(f_r) == 32'(filts_e) - 1);

endmodule

`default_nettype wire

@@ verif/conv1d_checker.sv @@
// ----------------------------------------------------------------------------
// conv1d_checker
// Watches the input, result and register ports of the strided 1-D convolution
// block. It keeps its own copy of the samples, weights, biases, counters and
// registers, and works out the per-filter sums that each accepted input item
// causes. Every result transfer is compared, field by field, with the oldest
// sum still owed.
// ----------------------------------------------------------------------------
`default_nettype none

module conv1d_checker (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_ready,
  input  smc1d_pkg::in_data_t  in_data,
  input  wire                  out_valid,
  input  wire                  out_ready,
  input  smc1d_pkg::out_data_t out_data,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire                  pready,
  input  wire [3:0]            paddr,
  input  wire [31:0]           pwdata,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SUM_HI = 64'sd549755813887;
  localparam longint SUM_LO = -64'sd549755813888;

  // Shadow copy of the block state.
  logic signed [15:0]   win_mem [4][8];
  logic signed [15:0]   wgt_mem [8][4][8];
  logic signed [15:0]   bias_mem [8];
  int unsigned          pos_cnt;
  int unsigned          phase_cnt;
  int unsigned          win_idx;
  logic [3:0]           r_stride, r_taps, r_filts;
  logic [2:0]           r_chans;
  smc1d_pkg::out_data_t owed_sums [$];
  int                   err_cnt;

  function automatic int unsigned clamp_cnt(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Applies one accepted input item and queues the sums it causes.
  task automatic apply_item(smc1d_pkg::in_data_t d);
    int unsigned          stride, taps, chans, filts;
    bit                   fire;
    longint               acc;
    smc1d_pkg::out_data_t r;
    stride = clamp_cnt(r_stride, 8);
    taps   = clamp_cnt(r_taps, 8);
    chans  = clamp_cnt(r_chans, 4);
    filts  = clamp_cnt(r_filts, 8);
    fire   = 1'b0;
    case (smc1d_pkg::cmd_t'(d.command))
      smc1d_pkg::CMD_WEIGHT:
        wgt_mem[d.filter_index][d.channel_index][d.tap_index] = d.value;
      smc1d_pkg::CMD_BIAS:    bias_mem[d.filter_index] = d.value;
      smc1d_pkg::CMD_RESTART: begin
        pos_cnt   = 0;
        phase_cnt = 0;
        win_idx   = 0;
      end
      default: begin
        if (d.channel_index < chans) begin
          for (int u = 7; u > 0; u--) win_mem[d.channel_index][u] = win_mem[d.channel_index][u-1];
          win_mem[d.channel_index][0] = d.value;
          if (d.channel_index == chans - 1) begin
            if (pos_cnt < 16'hFFFF) pos_cnt++;
            if (pos_cnt == taps) begin
              fire = 1'b1;
              phase_cnt = 0;
            end else if (pos_cnt > taps) begin
              if (phase_cnt + 1 >= stride) begin
                fire = 1'b1;
                phase_cnt = 0;
              end else begin
                phase_cnt = (phase_cnt + 1) & 7;
              end
            end
          end
        end
      end
    endcase
    if (fire) begin
      for (int f = 0; f < filts; f++) begin
        acc = longint'(bias_mem[f]) * 4096;
        for (int c = 0; c < chans; c++)
          for (int u = 0; u < taps; u++)
            acc += longint'(wgt_mem[f][c][u]) * longint'(win_mem[c][u]);
        if (acc > SUM_HI) acc = SUM_HI;
        if (acc < SUM_LO) acc = SUM_LO;
        r.filter_index_out = f[2:0];
        r.output_position  = win_idx[15:0];
        r.sum              = acc[39:0];
        r.last             = (f == filts - 1);
        owed_sums.insert(owed_sums.size(), r);
      end
      win_idx = (win_idx + 1) & 16'hFFFF;
    end
  endtask

  // Register writes, result comparison and input prediction, all sampled at the edge.
  always @(posedge clk) begin
    smc1d_pkg::out_data_t want;
    if (!rst_n) begin
      pos_cnt   = 0;
      phase_cnt = 0;
      win_idx   = 0;
      r_stride  = 4'd1;
      r_taps    = 4'd8;
      r_chans   = 3'd1;
      r_filts   = 4'd1;
      owed_sums.delete();
      err_cnt   = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (smc1d_pkg::reg_idx_t'(paddr[3:2]))
          smc1d_pkg::REG_STRIDE:   r_stride = pwdata[3:0];
          smc1d_pkg::REG_TAPS:     r_taps   = pwdata[3:0];
          smc1d_pkg::REG_CHANNELS: r_chans  = pwdata[2:0];
          smc1d_pkg::REG_FILTERS:  r_filts  = pwdata[3:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (owed_sums.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result transfer, got %p", $time, out_data);
        end else begin
          want = owed_sums.pop_front();
          if (out_data.filter_index_out !== want.filter_index_out) begin
            err_cnt++;
            $display("%0t: filter index expected %0d, got %0d", $time,
                     want.filter_index_out, out_data.filter_index_out);
          end
          if (out_data.output_position !== want.output_position) begin
            err_cnt++;
            $display("%0t: output position expected %0d, got %0d", $time,
                     want.output_position, out_data.output_position);
          end
          if (out_data.sum !== want.sum) begin
            err_cnt++;
            $display("%0t: sum expected %h, got %h", $time, want.sum, out_data.sum);
          end
          if (out_data.last !== want.last) begin
            err_cnt++;
            $display("%0t: last expected %b, got %b", $time, want.last, out_data.last);
          end
        end
      end
      if (in_valid && in_ready) apply_item(in_data);
    end
    errors  <= err_cnt;
    pending <= owed_sums.size();
  end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the strided 1-D convolution block. A short
// directed run at the reset settings is followed by random phases under
// several register settings and idle patterns; the checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 60;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  smc1d_pkg::in_data_t  in_data;
  logic                 out_valid;
  logic                 out_ready;
  smc1d_pkg::out_data_t out_data;
  logic                 psel, penable, pwrite;
  logic [3:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  int                   errors;
  int                   pending;

  // Stimulus bookkeeping: effective settings and which stores hold data.
  int          sender_idle;
  int          recv_stall;
  int          hold_req;
  int          e_taps, e_chans, e_filts;
  bit          wgt_set [8][4][8];
  bit          bias_set [8];
  int          win_fill [4];
  int          cycles;

  strided_multichannel_conv1d i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  conv1d_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off on request.
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // Offers one item, with random gaps first, and waits for its transfer.
  task automatic put_item(smc1d_pkg::cmd_t cmd, int fi, int ci, int ti, logic [15:0] v);
    smc1d_pkg::in_data_t d;
    d.command       = cmd;
    d.filter_index  = fi[2:0];
    d.channel_index = ci[1:0];
    d.tap_index     = ti[2:0];
    d.value         = v;
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (cmd)
      smc1d_pkg::CMD_WEIGHT: wgt_set[fi][ci][ti] = 1'b1;
      smc1d_pkg::CMD_BIAS:   bias_set[fi] = 1'b1;
      smc1d_pkg::CMD_SAMPLE: if (ci < e_chans) win_fill[ci]++;
      default: ;
    endcase
  endtask

  // Register write on the configuration port: a setup phase, then an access phase.
  task automatic write_reg(smc1d_pkg::reg_idx_t idx, int v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [15:0] rand_val();
    case ($urandom_range(5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Loads every weight and bias the current settings read that holds no data yet.
  task automatic load_missing();
    for (int f = 0; f < e_filts; f++) begin
      if (!bias_set[f]) put_item(smc1d_pkg::CMD_BIAS, f, 0, 0, rand_val());
      for (int c = 0; c < e_chans; c++)
        for (int t = 0; t < e_taps; t++)
          if (!wgt_set[f][c][t]) put_item(smc1d_pkg::CMD_WEIGHT, f, c, t, rand_val());
    end
  endtask

  task automatic send_position();
    for (int c = 0; c < e_chans; c++) put_item(smc1d_pkg::CMD_SAMPLE, 0, c, 0, rand_val());
  endtask

  function automatic bit windows_full();
    for (int c = 0; c < e_chans; c++)
      if (win_fill[c] < 8) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int clamp_cnt(int v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Stops offering items, then waits until every owed result has arrived and
  // the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // One random phase under the given settings and idle pattern. The position
  // count restarts so that the first window only covers samples sent since.
  task automatic run_phase(int stride, int taps, int chans, int filts,
                           int s_idle, int r_stall, int hold, int n_items);
    int cnt;
    int r;
    drain();
    write_reg(smc1d_pkg::REG_STRIDE, stride);
    write_reg(smc1d_pkg::REG_TAPS, taps);
    write_reg(smc1d_pkg::REG_CHANNELS, chans);
    write_reg(smc1d_pkg::REG_FILTERS, filts);
    e_taps      = clamp_cnt(taps, 8);
    e_chans     = clamp_cnt(chans, 4);
    e_filts     = clamp_cnt(filts, 8);
    sender_idle = s_idle;
    recv_stall  = r_stall;
    load_missing();
    put_item(smc1d_pkg::CMD_RESTART, 0, 0, 0, 16'd0);
    if (hold > 0) hold_req = hold;
    cnt = 0;
    while (cnt < n_items) begin
      r = $urandom_range(99);
      if (r < 70) begin
        send_position();
      end else if (r < 80) begin
        put_item(smc1d_pkg::CMD_WEIGHT, $urandom_range(7), $urandom_range(3),
                 $urandom_range(7), rand_val());
      end else if (r < 85) begin
        put_item(smc1d_pkg::CMD_BIAS, $urandom_range(7), $urandom_range(3),
                 $urandom_range(7), rand_val());
      end else if (r < 88) begin
        put_item(smc1d_pkg::CMD_RESTART, $urandom_range(7), $urandom_range(3),
                 $urandom_range(7), 16'($urandom()));
      end else if (r < 94) begin
        // Stray sample on a channel that does not complete a position.
        if (e_chans < 4)
          put_item(smc1d_pkg::CMD_SAMPLE, $urandom_range(7), $urandom_range(3, e_chans),
                   $urandom_range(7), 16'($urandom()));
        else
          put_item(smc1d_pkg::CMD_SAMPLE, 0, $urandom_range(2), 0, rand_val());
      end else if (windows_full()) begin
        // Broken position: only the closing channel arrives.
        put_item(smc1d_pkg::CMD_SAMPLE, 0, e_chans - 1, 0, rand_val());
      end else begin
        send_position();
      end
      cnt++;
    end
  endtask

  // Main sequence: reset, directed items, random phases, verdict.
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    hold_req    = 0;
    sender_idle = 0;
    recv_stall  = 0;
    e_taps      = 8;
    e_chans     = 1;
    e_filts     = 1;
    foreach (win_fill[c]) win_fill[c] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme bias and weights at the reset settings, then extreme samples.
    put_item(smc1d_pkg::CMD_BIAS, 0, 0, 0, 16'h7FFF);
    for (int t = 0; t < 8; t++) put_item(smc1d_pkg::CMD_WEIGHT, 0, 0, t, 16'h8000);
    for (int i = 0; i < 8; i++) put_item(smc1d_pkg::CMD_SAMPLE, 0, 0, 0, 16'h8000);
    put_item(smc1d_pkg::CMD_SAMPLE, 7, 3, 7, 16'hFFFF);
    put_item(smc1d_pkg::CMD_SAMPLE, 0, 0, 0, 16'h7FFF);
    put_item(smc1d_pkg::CMD_WEIGHT, 7, 3, 7, 16'h7FFF);
    put_item(smc1d_pkg::CMD_BIAS, 7, 0, 0, 16'h8000);
    put_item(smc1d_pkg::CMD_RESTART, 7, 3, 7, 16'hFFFF);
    for (int i = 0; i < 4; i++) put_item(smc1d_pkg::CMD_SAMPLE, 0, 0, 0, 16'h7FFF);

    // Random phases over several settings, extremes and out-of-range values included.
    run_phase(1, 1, 1, 1, 0, 0, 0, 6);
    run_phase(8, 2, 1, 8, 82, 0, 0, 8);
    run_phase(3, 4, 7, 1, 0, 82, 0, 7);
    run_phase(2, 5, 2, 3, 0, 0, 400, 8);
    run_phase(15, 0, 0, 15, 38, 38, 0, 8);
    run_phase(0, 15, 0, 0, 0, 0, 0, 10);
    run_phase(5, 3, 3, 4, 38, 38, 0, 5);

    drain();
    if (errors == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
